>>> src/length_prefixed_frame_deframer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed frame deframer
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpfd check failed");

// next-cycle implication, disabled during reset
`define LPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpfd check failed");

`endif

>>> src/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  typedef logic [1:0] kind_t;
  typedef logic [2:0] hdr_pos_t;

  localparam kind_t KIND_HEADER = 2'd0;
  localparam kind_t KIND_DATA   = 2'd1;
  localparam kind_t KIND_ERROR  = 2'd2;

  localparam hdr_pos_t POS_LEN0  = 3'd0;
  localparam hdr_pos_t POS_LEN1  = 3'd1;
  localparam hdr_pos_t POS_LEN2  = 3'd2;
  localparam hdr_pos_t POS_LEN3  = 3'd3;
  localparam hdr_pos_t POS_TYPE  = 3'd4;
  localparam hdr_pos_t POS_FLAGS = 3'd5;
  localparam hdr_pos_t POS_SEQ0  = 3'd6;
  localparam hdr_pos_t POS_SEQ1  = 3'd7;

  localparam logic [31:0] LEN_OVERHEAD = 32'd4;

endpackage

>>> src/length_prefixed_frame_deframer.sv
// A result is registered and appears on out_* in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the only limit is the single result register,
// which stalls the input only while a held result is itself stalled.
// Reset: synchronous active-low rst_n clears header position, payload flag and
// the result valid; the next byte after reset is header byte 0.
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream into an 8-byte header transaction (LE length, type,
// flags, LE sequence), one per payload byte, and an error for length < 4.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lpfd_pkg::kind_t      out_kind,
  output logic [7:0]           out_frame_type,
  output logic [7:0]           out_frame_flags,
  output logic [15:0]          out_sequence_res,
  output logic [31:0]          out_payload_length,
  output logic [7:0]           out_data_byte,
  output logic                 out_last
);

  lpfd_pkg::hdr_pos_t pos_r, pos_nxt;
  logic               in_payload_r, in_payload_nxt;
  logic [31:0]        len_r, len_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [7:0]         flags_r, flags_nxt;
  logic [15:0]        seq_r, seq_nxt;
  logic [31:0]        rem_r, rem_nxt;

  logic               out_valid_r, out_valid_nxt;
  lpfd_pkg::kind_t    kind_r, kind_nxt;
  logic [7:0]         otype_r, otype_nxt;
  logic [7:0]         oflags_r, oflags_nxt;
  logic [15:0]        oseq_r, oseq_nxt;
  logic [31:0]        oplen_r, oplen_nxt;
  logic [7:0]         odata_r, odata_nxt;
  logic               olast_r, olast_nxt;

  logic               accept;
  logic               res_load;
  logic [31:0]        rem_dec;
  logic [31:0]        plen;
  logic [31:0]        len_full;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign rem_dec  = rem_r - 32'd1;
  assign plen     = len_r - lpfd_pkg::LEN_OVERHEAD;
  assign len_full = {in_byte_in, len_r[23:0]};

  always_comb begin
    pos_nxt        = pos_r;
    in_payload_nxt = in_payload_r;
    len_nxt        = len_r;
    type_nxt       = type_r;
    flags_nxt      = flags_r;
    seq_nxt        = seq_r;
    rem_nxt        = rem_r;
    res_load       = 1'b0;
    kind_nxt       = kind_r;
    otype_nxt      = otype_r;
    oflags_nxt     = oflags_r;
    oseq_nxt       = oseq_r;
    oplen_nxt      = oplen_r;
    odata_nxt      = odata_r;
    olast_nxt      = olast_r;
    if (accept) begin
      if (in_payload_r) begin
        rem_nxt    = rem_dec;
        res_load   = 1'b1;
        kind_nxt   = lpfd_pkg::KIND_DATA;
        otype_nxt  = type_r;
        oflags_nxt = flags_r;
        oseq_nxt   = seq_r;
        oplen_nxt  = plen;
        odata_nxt  = in_byte_in;
        olast_nxt  = (rem_dec == 32'd0);
        if (rem_dec == 32'd0) begin
          in_payload_nxt = 1'b0;
          pos_nxt        = lpfd_pkg::POS_LEN0;
        end
      end else begin
        case (pos_r)
          lpfd_pkg::POS_LEN0: begin
            len_nxt = {24'd0, in_byte_in};
            pos_nxt = lpfd_pkg::POS_LEN1;
          end
          lpfd_pkg::POS_LEN1: begin
            len_nxt = {len_r[31:16], in_byte_in, len_r[7:0]};
            pos_nxt = lpfd_pkg::POS_LEN2;
          end
          lpfd_pkg::POS_LEN2: begin
            len_nxt = {len_r[31:24], in_byte_in, len_r[15:0]};
            pos_nxt = lpfd_pkg::POS_LEN3;
          end
          lpfd_pkg::POS_LEN3: begin
            len_nxt = len_full;
            if (len_full < lpfd_pkg::LEN_OVERHEAD) begin
              pos_nxt    = lpfd_pkg::POS_LEN0;
              res_load   = 1'b1;
              kind_nxt   = lpfd_pkg::KIND_ERROR;
              otype_nxt  = 8'd0;
              oflags_nxt = 8'd0;
              oseq_nxt   = 16'd0;
              oplen_nxt  = 32'd0;
              odata_nxt  = 8'd0;
              olast_nxt  = 1'b0;
            end else begin
              pos_nxt = lpfd_pkg::POS_TYPE;
            end
          end
          lpfd_pkg::POS_TYPE: begin
            type_nxt = in_byte_in;
            pos_nxt  = lpfd_pkg::POS_FLAGS;
          end
          lpfd_pkg::POS_FLAGS: begin
            flags_nxt = in_byte_in;
            pos_nxt   = lpfd_pkg::POS_SEQ0;
          end
          lpfd_pkg::POS_SEQ0: begin
            seq_nxt = {8'd0, in_byte_in};
            pos_nxt = lpfd_pkg::POS_SEQ1;
          end
          default: begin
            seq_nxt        = {in_byte_in, seq_r[7:0]};
            pos_nxt        = lpfd_pkg::POS_LEN0;
            rem_nxt        = plen;
            in_payload_nxt = (plen != 32'd0);
            res_load       = 1'b1;
            kind_nxt       = lpfd_pkg::KIND_HEADER;
            otype_nxt      = type_r;
            oflags_nxt     = flags_r;
            oseq_nxt       = {in_byte_in, seq_r[7:0]};
            oplen_nxt      = plen;
            odata_nxt      = 8'd0;
            olast_nxt      = (plen == 32'd0);
          end
        endcase
      end
    end
  end

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= lpfd_pkg::POS_LEN0;
      in_payload_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      in_payload_r <= in_payload_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    type_r   <= type_nxt;
    flags_r  <= flags_nxt;
    seq_r    <= seq_nxt;
    rem_r    <= rem_nxt;
    kind_r   <= kind_nxt;
    otype_r  <= otype_nxt;
    oflags_r <= oflags_nxt;
    oseq_r   <= oseq_nxt;
    oplen_r  <= oplen_nxt;
    odata_r  <= odata_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_frame_type     = otype_r;
  assign out_frame_flags    = oflags_r;
  assign out_sequence_res   = oseq_r;
  assign out_payload_length = oplen_r;
  assign out_data_byte      = odata_r;
  assign out_last           = olast_r;

endmodule

>>> src/lpfd_checker.sv
// ----------------------------------------------------------------------------
// lpfd_checker
// Port-level checks of the frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input lpfd_pkg::kind_t      out_kind,
  input logic [7:0]           out_frame_type,
  input logic [7:0]           out_frame_flags,
  input logic [15:0]          out_sequence_res,
  input logic [31:0]          out_payload_length,
  input logic [7:0]           out_data_byte,
  input logic                 out_last
);

  // a stalled result transaction holds
  `LPFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_kind) && $stable(out_payload_length) &&
    $stable(out_data_byte) && $stable(out_last))

  // input stalls only behind a held result
  `LPFD_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // error transaction carries zeroed fields
  `LPFD_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_kind == lpfd_pkg::KIND_ERROR,
    out_frame_type == 8'd0 && out_frame_flags == 8'd0 && out_sequence_res == 16'd0 &&
    out_payload_length == 32'd0 && out_data_byte == 8'd0 && !out_last)

  // header is last exactly when the payload is empty
  `LPFD_ASSERT_NOW(a_hdr_last, clk, rst_n, out_valid && out_kind == lpfd_pkg::KIND_HEADER,
    out_data_byte == 8'd0 && (out_last == (out_payload_length == 32'd0)))

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (.*);

>>> tb/length_prefixed_frame_deframer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_tb
// Drives a byte stream into the deframer and checks every header, payload
// and bad-length transaction against a typed table row or an in-bench model.
// A short table of hand-made frames comes first. Random frames follow, with
// bad lengths and empty payloads mixed in, and one frame with the largest
// length field closes the stream. Both sides idle at random.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_tb;

  typedef struct packed {
    lpfd_pkg::kind_t kind;
    logic [7:0]      ftype;
    logic [7:0]      flags;
    logic [15:0]     seq;
    logic [31:0]     plen;
    logic [7:0]      data;
    logic            last;
  } deframe_res_t;

  typedef struct packed {
    logic [7:0]      stim;
    logic            typed;
    lpfd_pkg::kind_t kind;
    logic [7:0]      ftype;
    logic [7:0]      flags;
    logic [15:0]     seq;
    logic [31:0]     plen;
    logic            last;
  } dir_row_t;

  localparam int DIR_N   = 26;
  localparam int RAND_N  = 400;
  localparam int SHOWN_N = 10;

  // hand-made frames; typed rows carry their expected transaction
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    // length 0: bad length
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b1, lpfd_pkg::KIND_ERROR,  8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    // length 3: bad length
    '{8'h03, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b1, lpfd_pkg::KIND_ERROR,  8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    // length 4: empty payload, header is last
    '{8'h04, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'hFF, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'hFF, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b1, lpfd_pkg::KIND_HEADER, 8'hFF, 8'h00, 16'h00FF, 32'h0, 1'b1},
    // length 6: two payload bytes
    '{8'h06, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'hFF, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h34, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h12, 1'b1, lpfd_pkg::KIND_HEADER, 8'h00, 8'hFF, 16'h1234, 32'h2, 1'b0},
    '{8'hFF, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0},
    '{8'h00, 1'b0, lpfd_pkg::KIND_HEADER, 8'h00, 8'h00, 16'h0000, 32'h0, 1'b0}
  };

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      in_byte_in = 8'h00;
  logic            out_valid;
  logic            out_stall = 1'b0;
  lpfd_pkg::kind_t out_kind;
  logic [7:0]      out_frame_type;
  logic [7:0]      out_frame_flags;
  logic [15:0]     out_sequence_res;
  logic [31:0]     out_payload_length;
  logic [7:0]      out_data_byte;
  logic            out_last;

  length_prefixed_frame_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte_in         (in_byte_in),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_frame_type     (out_frame_type),
    .out_frame_flags    (out_frame_flags),
    .out_sequence_res   (out_sequence_res),
    .out_payload_length (out_payload_length),
    .out_data_byte      (out_data_byte),
    .out_last           (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // byte stream and per-byte expectations
  logic [7:0]   stream_bytes [$];
  bit           stream_typed [$];
  deframe_res_t stream_res [$];
  deframe_res_t expected_q [$];
  int           sent_cnt = 0;
  int           err_cnt = 0;
  int           hdr_seen = 0;
  int           data_seen = 0;
  int           bad_seen = 0;

  // deframer state
  lpfd_pkg::hdr_pos_t hdr_pos = lpfd_pkg::POS_LEN0;
  bit                 in_body = 1'b0;
  logic [31:0]        len_acc = '0;
  logic [7:0]         type_q = '0;
  logic [7:0]         flags_q = '0;
  logic [15:0]        seq_q = '0;
  logic [31:0]        body_left = '0;

  function automatic bit deframe_byte(input logic [7:0] b, output deframe_res_t r);
    r = '0;
    if (in_body) begin
      body_left = body_left - 1;
      r = '{lpfd_pkg::KIND_DATA, type_q, flags_q, seq_q, len_acc - lpfd_pkg::LEN_OVERHEAD,
            b, body_left == 0};
      if (body_left == 0) begin
        in_body = 1'b0;
        hdr_pos = lpfd_pkg::POS_LEN0;
      end
      return 1'b1;
    end
    case (hdr_pos)
      lpfd_pkg::POS_LEN0: begin
        len_acc = {24'h0, b};
        hdr_pos = lpfd_pkg::POS_LEN1;
      end
      lpfd_pkg::POS_LEN1, lpfd_pkg::POS_LEN2: begin
        len_acc = len_acc | (32'(b) << (8 * hdr_pos));
        hdr_pos = lpfd_pkg::hdr_pos_t'(hdr_pos + 1);
      end
      lpfd_pkg::POS_LEN3: begin
        len_acc = len_acc | (32'(b) << 24);
        if (len_acc < lpfd_pkg::LEN_OVERHEAD) begin
          hdr_pos = lpfd_pkg::POS_LEN0;
          r.kind = lpfd_pkg::KIND_ERROR;
          return 1'b1;
        end
        hdr_pos = lpfd_pkg::POS_TYPE;
      end
      lpfd_pkg::POS_TYPE: begin
        type_q = b;
        hdr_pos = lpfd_pkg::POS_FLAGS;
      end
      lpfd_pkg::POS_FLAGS: begin
        flags_q = b;
        hdr_pos = lpfd_pkg::POS_SEQ0;
      end
      lpfd_pkg::POS_SEQ0: begin
        seq_q = {8'h00, b};
        hdr_pos = lpfd_pkg::POS_SEQ1;
      end
      default: begin
        seq_q = {b, seq_q[7:0]};
        hdr_pos = lpfd_pkg::POS_LEN0;
        body_left = len_acc - lpfd_pkg::LEN_OVERHEAD;
        in_body = body_left != 0;
        r = '{lpfd_pkg::KIND_HEADER, type_q, flags_q, seq_q, body_left, 8'h00,
              body_left == 0};
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic string fmt_res(input deframe_res_t r);
    return $sformatf("kind=%0d type=%02h flags=%02h seq=%04h len=%08h data=%02h last=%0d",
                     r.kind, r.ftype, r.flags, r.seq, r.plen, r.data, r.last);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    stream_bytes.insert(stream_bytes.size(), b);
    stream_typed.insert(stream_typed.size(), 1'b0);
    stream_res.insert(stream_res.size(), deframe_res_t'(0));
  endtask

  // length bytes, then header and payload unless the length is bad
  task automatic add_frame(input logic [31:0] len_field, input int n_body);
    logic [15:0] seq;
    seq = 16'($urandom);
    for (int k = 0; k < 4; k++) add_byte(len_field[8 * k +: 8]);
    if (len_field >= lpfd_pkg::LEN_OVERHEAD) begin
      add_byte(8'($urandom));
      add_byte(8'($urandom));
      add_byte(seq[7:0]);
      add_byte(seq[15:8]);
      for (int k = 0; k < n_body; k++) add_byte(8'($urandom));
    end
  endtask

  always @(posedge clk) begin
    deframe_res_t pred;
    deframe_res_t got;
    deframe_res_t exp_r;
    bit           has_res;
    bit           go;
    int           phase;
    int           send_pct;
    int           recv_pct;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      phase = (stream_bytes.size() == 0) ? 2 : (sent_cnt * 3) / stream_bytes.size();
      send_pct = (phase == 0) ? 8 : (phase == 1) ? 45 : 0;
      recv_pct = (phase == 0) ? 45 : (phase == 1) ? 8 : 0;

      if (in_valid && !in_stall) begin
        has_res = deframe_byte(in_byte_in, pred);
        if (stream_typed[sent_cnt]) expected_q.insert(expected_q.size(), stream_res[sent_cnt]);
        else if (has_res) expected_q.insert(expected_q.size(), pred);
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        go = (sent_cnt < stream_bytes.size()) && ($urandom_range(99) >= send_pct);
        in_valid <= go;
        if (go) in_byte_in <= stream_bytes[sent_cnt];
      end

      if (out_valid && !out_stall) begin
        got = '{out_kind, out_frame_type, out_frame_flags, out_sequence_res,
                out_payload_length, out_data_byte, out_last};
        case (got.kind)
          lpfd_pkg::KIND_HEADER: hdr_seen++;
          lpfd_pkg::KIND_DATA:   data_seen++;
          default:               bad_seen++;
        endcase
        if (expected_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOWN_N) $display("unexpected transaction: %s", fmt_res(got));
        end else begin
          exp_r = expected_q.pop_front();
          if (got.kind !== exp_r.kind || got.ftype !== exp_r.ftype ||
              got.flags !== exp_r.flags || got.seq !== exp_r.seq ||
              got.plen !== exp_r.plen || got.data !== exp_r.data ||
              got.last !== exp_r.last) begin
            err_cnt++;
            if (err_cnt <= SHOWN_N) begin
              $display("mismatch at %0t", $realtime);
              $display("  expected %s", fmt_res(exp_r));
              $display("  actual   %s", fmt_res(got));
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  initial begin
    int mode;
    int n_body;
    int drain;
    for (int i = 0; i < DIR_N; i++) begin
      stream_bytes.insert(stream_bytes.size(), DIR_TAB[i].stim);
      stream_typed.insert(stream_typed.size(), DIR_TAB[i].typed);
      stream_res.insert(stream_res.size(),
                        deframe_res_t'{DIR_TAB[i].kind, DIR_TAB[i].ftype, DIR_TAB[i].flags,
                                       DIR_TAB[i].seq, DIR_TAB[i].plen, 8'h00,
                                       DIR_TAB[i].last});
    end
    while (stream_bytes.size() < DIR_N + RAND_N) begin
      mode = $urandom_range(99);
      if (mode < 15) begin
        add_frame(32'($urandom_range(3)), 0);
      end else begin
        if (mode < 25) n_body = 0;
        else if (mode < 90) n_body = $urandom_range(12, 1);
        else n_body = $urandom_range(48, 13);
        add_frame(32'(n_body) + lpfd_pkg::LEN_OVERHEAD, n_body);
      end
    end
    // largest length field; only its first six payload bytes are sent
    add_frame(32'hFFFF_FFFF, 6);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < stream_bytes.size()) @(posedge clk);
    drain = 0;
    while (expected_q.size() != 0 && drain < 1000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0d expected transactions never arrived", expected_q.size());
      err_cnt += expected_q.size();
    end

    $display("sent %0d stream bytes; checked %0d headers, %0d payload bytes, %0d bad lengths",
             sent_cnt, hdr_seen, data_seen, bad_seen);
    $display("mismatches: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("length_prefixed_frame_deframer_tb passed");
    end else begin
      $display("length_prefixed_frame_deframer_tb failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("length_prefixed_frame_deframer_tb failed");
    $finish;
  end

endmodule
